FILE: design/accel_tilt_angles_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the accelerometer tilt angle block
// ---------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_DEFINES_SVH
`define ACCEL_TILT_ANGLES_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ATC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ATC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/atc_pkg.sv
// ---------------------------------------------------------------------------
// atc_pkg
// Types, constants and the arctangent table of the tilt angle block.
// ---------------------------------------------------------------------------
package atc_pkg;

  localparam int ANGLE_FRAC_BITS   = 8;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ACC_FRAC          = 16;
  localparam int ROUND_SHIFT       = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int SQRT_STEPS        = 23;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int ANGLE_ACC_W       = 25;
  localparam int CORDIC_W          = 27;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;

  localparam logic signed [ANGLE_ACC_W-1:0] RIGHT_ANGLE = ANGLE_ACC_W'(90 << ACC_FRAC);

  // Arctangent of 2^-i in degrees with sixteen fraction bits.
  localparam int ATAN_TAB [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [14:0] x;
    logic signed [14:0] y;
    logic signed [14:0] z;
  } atc_sample_t;

  typedef struct packed {
    logic        valid;
    atc_sample_t data;
  } atc_queue_out_t;

  typedef struct packed {
    logic [14:0] ax;
    logic [14:0] ay;
    logic [14:0] az;
    logic        xpos;
    logic        ypos;
    logic        zneg;
    logic        zero;
  } atc_side_t;

  typedef struct packed {
    logic [14:0] mag;
    logic [2:0]  nz;
    logic [2:0]  dz;
    logic        xpos;
    logic        ypos;
    logic        zneg;
    logic        zero;
  } atc_cside_t;

endpackage

FILE: design/atc_front.sv
// ---------------------------------------------------------------------------
// atc_front
// Holds the offset registers, unpacks the three axis words and adds offsets.
// ---------------------------------------------------------------------------
module atc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [13:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         x_word_i,
  input  logic [15:0]         y_word_i,
  input  logic [15:0]         z_word_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output atc_pkg::atc_sample_t q_data_o
);

  logic signed [13:0] off_x_q, off_y_q, off_z_q;
  logic               valid_q;
  atc_pkg::atc_sample_t smp_q, smp_d;
  logic               load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        atc_pkg::REG_OFFSET_X: off_x_q <= cfg_data_i;
        atc_pkg::REG_OFFSET_Y: off_y_q <= cfg_data_i;
        atc_pkg::REG_OFFSET_Z: off_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = valid_q & q_full_i;
  assign load       = ~valid_q | ~q_full_i;
  assign q_push_o   = valid_q & ~q_full_i;
  assign q_data_o   = smp_q;

  always_comb begin
    smp_d.x = 15'(signed'(x_word_i[15:2])) + 15'(off_x_q);
    smp_d.y = 15'(signed'(y_word_i[15:2])) + 15'(off_y_q);
    smp_d.z = 15'(signed'(z_word_i[15:2])) + 15'(off_z_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      smp_q <= smp_d;
    end
  end

endmodule

FILE: design/atc_queue.sv
// ---------------------------------------------------------------------------
// atc_queue
// Short queue of corrected samples between the front and the back.
// ---------------------------------------------------------------------------
module atc_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  atc_pkg::atc_sample_t    data_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output atc_pkg::atc_queue_out_t head_o
);

  atc_pkg::atc_sample_t mem_q [atc_pkg::QUEUE_DEPTH];
  logic [atc_pkg::QUEUE_PTR_W-1:0] wr_q, rd_q;
  logic [atc_pkg::QUEUE_PTR_W:0]   cnt_q;

  assign full_o       = (cnt_q == (atc_pkg::QUEUE_PTR_W+1)'(atc_pkg::QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (atc_pkg::QUEUE_PTR_W+1)'(push_i) - (atc_pkg::QUEUE_PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: design/atc_back.sv
// ---------------------------------------------------------------------------
// atc_back
// Squares, four pipelined square roots, three pipelined vectoring CORDICs
// and the output register.
// ---------------------------------------------------------------------------
module atc_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  atc_pkg::atc_queue_out_t head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [15:0]      pitch_angle_o,
  output logic signed [15:0]      roll_angle_o,
  output logic signed [15:0]      tilt_angle_o,
  output logic [14:0]             magnitude_o,
  output logic                    zero_vector_o
);

  localparam int NS = atc_pkg::SQRT_STEPS;
  localparam int NC = atc_pkg::CORDIC_ITERATIONS;
  localparam int CW = atc_pkg::CORDIC_W;
  localparam int AW = atc_pkg::ANGLE_ACC_W;

  logic en;

  // Squares stage.
  logic               va_q;
  logic [29:0]        sq_q [3];
  atc_pkg::atc_side_t sa_q, sa_d;

  // Square root stages, element 0 holds the sums.
  logic               rv_q    [NS+1];
  logic [29:0]        rs_q    [NS+1][4];
  logic [24:0]        rrem_q  [NS+1][4];
  logic [22:0]        rroot_q [NS+1][4];
  atc_pkg::atc_side_t rside_q [NS+1];
  logic [24:0]        rrem_d  [NS][4];
  logic [22:0]        rroot_d [NS][4];

  // CORDIC stages, element 0 holds the starting vectors.
  logic                   cv_q  [NC+1];
  logic signed [CW-1:0]   cx_q  [NC+1][3];
  logic signed [CW-1:0]   cy_q  [NC+1][3];
  logic signed [AW-1:0]   cz_q  [NC+1][3];
  atc_pkg::atc_cside_t    cs_q  [NC+1];
  logic signed [CW-1:0]   cx_d  [NC][3];
  logic signed [CW-1:0]   cy_d  [NC][3];
  logic signed [AW-1:0]   cz_d  [NC][3];
  logic [22:0]            num0  [3];
  logic [22:0]            den0  [3];
  atc_pkg::atc_cside_t    cs0;

  logic                   out_valid_q;
  logic [14:0]            ang_mag [3];
  logic signed [15:0]     ang_d   [3];
  logic signed [15:0]     pitch_q, roll_q, tilt_q;
  logic [14:0]            mag_q;
  logic                   zero_q;

  assign en          = ~out_valid_q | ~out_stall_i;
  assign pop_o       = en & head_i.valid;
  assign out_valid_o = out_valid_q;

  always_comb begin
    sa_d.ax   = (head_i.data.x < 0) ? 15'(-head_i.data.x) : 15'(head_i.data.x);
    sa_d.ay   = (head_i.data.y < 0) ? 15'(-head_i.data.y) : 15'(head_i.data.y);
    sa_d.az   = (head_i.data.z < 0) ? 15'(-head_i.data.z) : 15'(head_i.data.z);
    sa_d.xpos = (head_i.data.x > 0);
    sa_d.ypos = (head_i.data.y > 0);
    sa_d.zneg = (head_i.data.z < 0);
    sa_d.zero = (head_i.data.x == 0) && (head_i.data.y == 0) && (head_i.data.z == 0);
  end

  // One result bit per stage: bring down the next two radicand bits and try
  // to subtract the trial value. The radicand is the sum times 2^16.
  always_comb begin
    logic [45:0] rad;
    logic [26:0] rem_n;
    logic [26:0] trial;
    for (int k = 0; k < NS; k++) begin
      for (int l = 0; l < 4; l++) begin
        rad   = {rs_q[k][l], 16'b0};
        rem_n = {rrem_q[k][l], rad[45-2*k -: 2]};
        trial = {2'b00, rroot_q[k][l], 2'b01};
        if (rem_n >= trial) begin
          rrem_d[k][l]  = 25'(rem_n - trial);
          rroot_d[k][l] = {rroot_q[k][l][21:0], 1'b1};
        end else begin
          rrem_d[k][l]  = 25'(rem_n);
          rroot_d[k][l] = {rroot_q[k][l][21:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    num0[0] = {rside_q[NS].ax, 8'b0};
    den0[0] = rroot_q[NS][1];
    num0[1] = {rside_q[NS].ay, 8'b0};
    den0[1] = rroot_q[NS][2];
    num0[2] = rroot_q[NS][3];
    den0[2] = {rside_q[NS].az, 8'b0};
    cs0.mag  = rroot_q[NS][0][22:8];
    cs0.xpos = rside_q[NS].xpos;
    cs0.ypos = rside_q[NS].ypos;
    cs0.zneg = rside_q[NS].zneg;
    cs0.zero = rside_q[NS].zero;
    for (int a = 0; a < 3; a++) begin
      cs0.nz[a] = (num0[a] == '0);
      cs0.dz[a] = (den0[a] == '0);
    end
  end

  // Rotate toward the x axis; the sign of y picks the direction.
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      for (int a = 0; a < 3; a++) begin
        if (cy_q[i][a] > 0) begin
          cx_d[i][a] = cx_q[i][a] + (cy_q[i][a] >>> i);
          cy_d[i][a] = cy_q[i][a] - (cx_q[i][a] >>> i);
          cz_d[i][a] = cz_q[i][a] + AW'(atc_pkg::ATAN_TAB[i]);
        end else begin
          cx_d[i][a] = cx_q[i][a] - (cy_q[i][a] >>> i);
          cy_d[i][a] = cy_q[i][a] + (cx_q[i][a] >>> i);
          cz_d[i][a] = cz_q[i][a] - AW'(atc_pkg::ATAN_TAB[i]);
        end
      end
    end
  end

  always_comb begin
    logic signed [AW-1:0] zc;
    logic [AW-1:0]        rnd;
    for (int a = 0; a < 3; a++) begin
      if (cs_q[NC].dz[a]) begin
        zc = atc_pkg::RIGHT_ANGLE;
      end else if (cz_q[NC][a] < 0) begin
        zc = '0;
      end else if (cz_q[NC][a] > atc_pkg::RIGHT_ANGLE) begin
        zc = atc_pkg::RIGHT_ANGLE;
      end else begin
        zc = cz_q[NC][a];
      end
      rnd = (AW'(zc) + AW'(1 << (atc_pkg::ROUND_SHIFT - 1))) >> atc_pkg::ROUND_SHIFT;
      if (cs_q[NC].nz[a] || cs_q[NC].zero) begin
        ang_mag[a] = '0;
      end else if (rnd > AW'(32767)) begin
        ang_mag[a] = 15'h7FFF;
      end else begin
        ang_mag[a] = 15'(rnd);
      end
    end
    ang_d[0] = cs_q[NC].xpos ? -signed'({1'b0, ang_mag[0]}) : signed'({1'b0, ang_mag[0]});
    ang_d[1] = cs_q[NC].ypos ? -signed'({1'b0, ang_mag[1]}) : signed'({1'b0, ang_mag[1]});
    ang_d[2] = cs_q[NC].zneg ? -signed'({1'b0, ang_mag[2]}) : signed'({1'b0, ang_mag[2]});
  end

  // Valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= NS; k++) rv_q[k] <= 1'b0;
      for (int i = 0; i <= NC; i++) cv_q[i] <= 1'b0;
    end else if (en) begin
      va_q    <= pop_o;
      rv_q[0] <= va_q;
      for (int k = 0; k < NS; k++) rv_q[k+1] <= rv_q[k];
      cv_q[0] <= rv_q[NS];
      for (int i = 0; i < NC; i++) cv_q[i+1] <= cv_q[i];
      out_valid_q <= cv_q[NC];
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q     <= sa_d;
      sq_q[0]  <= sa_d.ax * sa_d.ax;
      sq_q[1]  <= sa_d.ay * sa_d.ay;
      sq_q[2]  <= sa_d.az * sa_d.az;

      rs_q[0][0] <= sq_q[0] + sq_q[1] + sq_q[2];
      rs_q[0][1] <= sq_q[1] + sq_q[2];
      rs_q[0][2] <= sq_q[0] + sq_q[2];
      rs_q[0][3] <= sq_q[0] + sq_q[1];
      for (int l = 0; l < 4; l++) begin
        rrem_q[0][l]  <= '0;
        rroot_q[0][l] <= '0;
      end
      rside_q[0] <= sa_q;
      for (int k = 0; k < NS; k++) begin
        rside_q[k+1] <= rside_q[k];
        for (int l = 0; l < 4; l++) begin
          rs_q[k+1][l]    <= rs_q[k][l];
          rrem_q[k+1][l]  <= rrem_d[k][l];
          rroot_q[k+1][l] <= rroot_d[k][l];
        end
      end

      cs_q[0] <= cs0;
      for (int a = 0; a < 3; a++) begin
        cx_q[0][a] <= CW'(den0[a]);
        cy_q[0][a] <= CW'(num0[a]);
        cz_q[0][a] <= '0;
      end
      for (int i = 0; i < NC; i++) begin
        cs_q[i+1] <= cs_q[i];
        for (int a = 0; a < 3; a++) begin
          cx_q[i+1][a] <= cx_d[i][a];
          cy_q[i+1][a] <= cy_d[i][a];
          cz_q[i+1][a] <= cz_d[i][a];
        end
      end

      pitch_q <= ang_d[0];
      roll_q  <= ang_d[1];
      tilt_q  <= ang_d[2];
      mag_q   <= cs_q[NC].mag;
      zero_q  <= cs_q[NC].zero;
    end
  end

  assign pitch_angle_o = pitch_q;
  assign roll_angle_o  = roll_q;
  assign tilt_angle_o  = tilt_q;
  assign magnitude_o   = mag_q;
  assign zero_vector_o = zero_q;

endmodule

FILE: design/accel_tilt_angles.sv
// ---------------------------------------------------------------------------
// accel_tilt_angles
// Pitch, roll, tilt and vector length of one three-axis accelerometer sample.
// ---------------------------------------------------------------------------
//   channel  | handshake               | payload
//   input    | in_valid_i / in_stall_o | x_word_i, y_word_i, z_word_i
//   output   | out_valid_o/ out_stall_i| pitch/roll/tilt_angle_o, magnitude_o,
//            |                         | zero_vector_o
//   config   | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One request is taken every cycle while in_stall_o is low; each of the 23
// square root steps and the 16 CORDIC steps is one register stage.
// Reset clears all offsets to zero and empties every stage.
// An output stall freezes the back pipeline; the four-entry queue lets the
// front keep taking requests until it fills.
// ---------------------------------------------------------------------------
module accel_tilt_angles (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [13:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        x_word_i,
  input  logic [15:0]        y_word_i,
  input  logic [15:0]        z_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] tilt_angle_o,
  output logic [14:0]        magnitude_o,
  output logic               zero_vector_o
);

  logic                    q_full, q_push, q_pop;
  atc_pkg::atc_sample_t    q_data;
  atc_pkg::atc_queue_out_t q_head;

  atc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .x_word_i    (x_word_i),
    .y_word_i    (y_word_i),
    .z_word_i    (z_word_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_data)
  );

  atc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_data),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  atc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pitch_angle_o (pitch_angle_o),
    .roll_angle_o  (roll_angle_o),
    .tilt_angle_o  (tilt_angle_o),
    .magnitude_o   (magnitude_o),
    .zero_vector_o (zero_vector_o)
  );

endmodule

FILE: design/atc_checker.sv
// ---------------------------------------------------------------------------
// atc_checker
// Port-level checks of the tilt angle block.
// ---------------------------------------------------------------------------
`include "accel_tilt_angles_defines.svh"

module atc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] pitch_angle_o,
  input logic signed [15:0] roll_angle_o,
  input logic signed [15:0] tilt_angle_o,
  input logic [14:0]        magnitude_o,
  input logic               zero_vector_o
);

  `ATC_ASSERT_NEXT(a_valid_holds, out_valid_o && out_stall_i, out_valid_o)
  `ATC_ASSERT_NEXT(a_payload_holds, out_valid_o && out_stall_i,
    $stable(pitch_angle_o) && $stable(roll_angle_o) && $stable(tilt_angle_o) && $stable(magnitude_o))
  `ATC_ASSERT_IMP(a_zero_result, out_valid_o && zero_vector_o,
    pitch_angle_o == 16'sd0 && roll_angle_o == 16'sd0 && tilt_angle_o == 16'sd0 && magnitude_o == 15'd0)
  `ATC_ASSERT_IMP(a_angle_range, out_valid_o,
    pitch_angle_o <= 16'sd23040 && pitch_angle_o >= -16'sd23040 && tilt_angle_o <= 16'sd23040 && tilt_angle_o >= -16'sd23040)

endmodule

bind accel_tilt_angles atc_checker u_atc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pitch_angle_o (pitch_angle_o),
  .roll_angle_o  (roll_angle_o),
  .tilt_angle_o  (tilt_angle_o),
  .magnitude_o   (magnitude_o),
  .zero_vector_o (zero_vector_o)
);

FILE: dv/tb_accel_tilt_angles.sv
// ---------------------------------------------------------------------------
// Tilt angle block testbench
// Drives accelerometer samples through the block under random idling and a
// long output hold-off, predicts pitch, roll, tilt and vector length for each
// request and compares every result in order. Offsets are rewritten between
// phases while the pipeline is empty.
// ---------------------------------------------------------------------------
module tb_accel_tilt_angles;

  localparam int LATENCY     = 44;
  localparam int RANDOM_REQS = 700;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] tilt;
    logic [14:0]        mag;
    logic               zero;
  } tilt_result_t;

  typedef struct {
    logic [15:0]  xw;
    logic [15:0]  yw;
    logic [15:0]  zw;
    logic         typed;
    tilt_result_t res;
  } sample_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [13:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [15:0]        x_word_i = '0;
  logic [15:0]        y_word_i = '0;
  logic [15:0]        z_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] pitch_angle_o;
  logic signed [15:0] roll_angle_o;
  logic signed [15:0] tilt_angle_o;
  logic [14:0]        magnitude_o;
  logic               zero_vector_o;

  accel_tilt_angles uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic signed [13:0] off_x, off_y, off_z;
  tilt_result_t       pending_results[$];
  int                 errors = 0;
  int                 results_seen = 0;
  int                 zero_seen = 0;
  int                 cycles = 0;
  bit                 hold_off = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC on n over d, both non-negative, angle in degrees.
  function automatic int atan_degrees(longint unsigned n, longint unsigned d);
    longint cx, cy, cz, xs, ys, r;
    int steps;
    cx = d;
    cy = n;
    cz = 0;
    steps = (atc_pkg::CORDIC_ITERATIONS > 24) ? 24 : atc_pkg::CORDIC_ITERATIONS;
    if (n == 0) return 0;
    if (d == 0) begin
      cz = longint'(90) << atc_pkg::ACC_FRAC;
    end else begin
      for (int i = 0; i < steps; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (cy > 0) begin
          cx = cx + ys;
          cy = cy - xs;
          cz = cz + atc_pkg::ATAN_TAB[i];
        end else begin
          cx = cx - ys;
          cy = cy + xs;
          cz = cz - atc_pkg::ATAN_TAB[i];
        end
      end
      if (cz < 0) cz = 0;
      if (cz > (longint'(90) << atc_pkg::ACC_FRAC)) cz = longint'(90) << atc_pkg::ACC_FRAC;
    end
    r = (cz + (longint'(1) << (atc_pkg::ROUND_SHIFT - 1))) >>> atc_pkg::ROUND_SHIFT;
    if (r > 32767) r = 32767;
    return int'(r);
  endfunction

  function automatic longint unsigned root_of(longint a, longint b);
    return int_sqrt((a * a + b * b) << 16);
  endfunction

  function automatic longint unsigned abs_of(longint a);
    return (a < 0 ? -a : a) << 8;
  endfunction

  function automatic tilt_result_t predict_angles(logic [15:0] xw, logic [15:0] yw,
                                                  logic [15:0] zw);
    tilt_result_t r;
    longint x, y, z;
    int p, q, t;
    x = longint'($signed(xw[15:2])) + longint'(off_x);
    y = longint'($signed(yw[15:2])) + longint'(off_y);
    z = longint'($signed(zw[15:2])) + longint'(off_z);
    r = '0;
    if (x == 0 && y == 0 && z == 0) begin
      r.zero = 1'b1;
      return r;
    end
    r.mag = 15'(int_sqrt(x * x + y * y + z * z));
    p = atan_degrees(abs_of(x), root_of(y, z));
    q = atan_degrees(abs_of(y), root_of(x, z));
    t = atan_degrees(root_of(x, y), abs_of(z));
    r.pitch = 16'(x > 0 ? -p : p);
    r.roll  = 16'(y > 0 ? -q : q);
    r.tilt  = 16'(z < 0 ? -t : t);
    return r;
  endfunction

  task automatic write_offset(logic [1:0] idx, logic signed [13:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      atc_pkg::REG_OFFSET_X: off_x = val;
      atc_pkg::REG_OFFSET_Y: off_y = val;
      atc_pkg::REG_OFFSET_Z: off_z = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_offsets(logic signed [13:0] ox, logic signed [13:0] oy,
                             logic signed [13:0] oz);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    write_offset(atc_pkg::REG_OFFSET_X, ox);
    write_offset(atc_pkg::REG_OFFSET_Y, oy);
    write_offset(atc_pkg::REG_OFFSET_Z, oz);
  endtask

  // Predicts when the sample is presented; the caller has already waited out its idle gap.
  task automatic send_sample(logic [15:0] xw, logic [15:0] yw, logic [15:0] zw,
                             bit typed, tilt_result_t typed_res);
    tilt_result_t exp_res;
    in_valid_i <= 1'b1;
    x_word_i   <= xw;
    y_word_i   <= yw;
    z_word_i   <= zw;
    exp_res = typed ? typed_res : predict_angles(xw, yw, zw);
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(exp_res);
  endtask

  task automatic idle_then_send(logic [15:0] xw, logic [15:0] yw, logic [15:0] zw,
                                bit typed, tilt_result_t typed_res, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    send_sample(xw, yw, zw, typed, typed_res);
  endtask

  function automatic logic [15:0] word_of(int counts);
    return {14'(counts), 2'($urandom_range(0, 3))};
  endfunction

  // Mostly realistic tilts of a 1 g vector, with full-range noise mixed in.
  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return word_of($urandom_range(0, 8) - 4);
      default: return word_of(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  sample_row_t directed_rows[$];

  function automatic sample_row_t mk_row(int xc, int yc, int zc, bit typed,
                                         tilt_result_t res);
    sample_row_t row;
    row.xw = {14'(xc), 2'b00};
    row.yw = {14'(yc), 2'b00};
    row.zw = {14'(zc), 2'b00};
    row.typed = typed;
    row.res = res;
    return row;
  endfunction

  // Receiver: random stalls, one long hold-off on request, in-order checking.
  always @(posedge clk_i) begin
    int stall_left;
    tilt_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (zero_vector_o) zero_seen++;
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (pitch_angle_o !== want.pitch) begin
            $error("pitch_angle expected %0d got %0d", want.pitch, pitch_angle_o);
            errors++;
          end
          if (roll_angle_o !== want.roll) begin
            $error("roll_angle expected %0d got %0d", want.roll, roll_angle_o);
            errors++;
          end
          if (tilt_angle_o !== want.tilt) begin
            $error("tilt_angle expected %0d got %0d", want.tilt, tilt_angle_o);
            errors++;
          end
          if (magnitude_o !== want.mag) begin
            $error("magnitude expected %0d got %0d", want.mag, magnitude_o);
            errors++;
          end
          if (zero_vector_o !== want.zero) begin
            $error("zero_vector expected %0b got %0b", want.zero, zero_vector_o);
            errors++;
          end
        end
      end
      if (hold_off) begin
        out_stall_i <= 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // The long hold-off counts its own cycles. It starts in the middle of the
  // first random phase, so the sender keeps offering requests behind it.
  initial begin
    wait (rst_ni);
    wait (results_seen >= 100);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    tilt_result_t zero_res, none;
    tilt_result_t t;
    sample_row_t row;
    int settle;
    none = '0;
    zero_res = '0;
    zero_res.zero = 1'b1;
    off_x = '0;
    off_y = '0;
    off_z = '0;

    // Zero vector, axis extremes and exact right angles.
    directed_rows.push_back(mk_row(0, 0, 0, 1'b1, zero_res));
    t = '0; t.mag = 15'd100; t.tilt = 16'sd0;
    directed_rows.push_back(mk_row(0, 0, 100, 1'b1, t));
    t = '0; t.mag = 15'd100; t.pitch = -16'sd23040; t.tilt = 16'sd23040;
    directed_rows.push_back(mk_row(100, 0, 0, 1'b1, t));
    t = '0; t.mag = 15'd100; t.roll = 16'sd23040; t.tilt = 16'sd23040;
    directed_rows.push_back(mk_row(0, -100, 0, 1'b1, t));
    t = '0; t.mag = 15'd8192; t.tilt = -16'sd0;
    directed_rows.push_back(mk_row(0, 0, -8192, 1'b1, t));
    directed_rows.push_back(mk_row(8191, 8191, 8191, 1'b0, none));
    directed_rows.push_back(mk_row(-8192, -8192, -8192, 1'b0, none));
    directed_rows.push_back(mk_row(-8192, 8191, -1, 1'b0, none));
    directed_rows.push_back(mk_row(1, 1, 1, 1'b0, none));
    directed_rows.push_back(mk_row(-1, 0, 1, 1'b0, none));
    directed_rows.push_back(mk_row(0, 3000, 4000, 1'b0, none));
    directed_rows.push_back(mk_row(4096, 0, 4096, 1'b0, none));
    directed_rows.push_back(mk_row(5, -5, 0, 1'b0, none));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      // Status bits toggle here so both values of bits 1:0 appear.
      row.xw[1:0] = 2'(i);
      row.yw[1:0] = 2'(i + 1);
      row.zw[1:0] = 2'(i + 2);
      idle_then_send(row.xw, row.yw, row.zw, row.typed, row.res, 1'b1);
    end
    in_valid_i <= 1'b0;

    // Offset extremes: corrected counts reach the ends of their range.
    set_offsets(14'sd8191, -14'sd8192, 14'sd8191);
    idle_then_send({14'sd8191, 2'b11}, {-14'sd8192, 2'b00}, 16'hFFFF, 1'b0, none, 1'b0);
    idle_then_send({-14'sd8192, 2'b10}, {14'sd8191, 2'b01}, {-14'sd8191, 2'b00},
                   1'b0, none, 1'b0);
    in_valid_i <= 1'b0;
    set_offsets(-14'sd8192, 14'sd8191, -14'sd8192);
    idle_then_send({14'sd8192, 2'b00}, {-14'sd8191, 2'b00}, {14'sd8192, 2'b00},
                   1'b0, none, 1'b0);
    idle_then_send(16'h8000, 16'h7FFF, 16'h8001, 1'b0, none, 1'b0);
    in_valid_i <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_offsets('0, '0, '0);
        1: set_offsets(14'sd20, -14'sd35, 14'sd3);
        2: set_offsets(14'($urandom), 14'($urandom), 14'($urandom));
        default: set_offsets(-14'sd1, 14'sd1, -14'sd4096);
      endcase
      for (int k = 0; k < RANDOM_REQS / 4; k++)
        idle_then_send(random_word(), random_word(), random_word(), 1'b0, none,
                       ($urandom_range(0, 9) < 6) && (k % 64 < 48));
      in_valid_i <= 1'b0;
    end

    settle = 0;
    while (pending_results.size() != 0 && settle < 20000) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (LATENCY + 8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end

    $display("Checked %0d results (%0d zero vectors) over seven offset settings.",
             results_seen, zero_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
